[rtl/core/heading_hold_drive_mixer_core_assert.svh]
// Assertion macros shared by the heading hold drive mixer RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef HEADING_HOLD_DRIVE_MIXER_CORE_ASSERT_SVH
`define HEADING_HOLD_DRIVE_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HHDM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HHDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/hhdm_pkg.sv]
// Shared types, constants and helper functions of the heading hold drive mixer.
// Depends on nothing; the mode, multiply and mixer stages and the top level use it.
`timescale 1ns / 1ps
`default_nettype none

package hhdm_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_P_GAIN           = 3'd0;
	localparam logic [2:0] CFG_D_GAIN           = 3'd1;
	localparam logic [2:0] CFG_CORRECTION_RATIO = 3'd2;
	localparam logic [2:0] CFG_DEADBAND         = 3'd3;
	localparam logic [2:0] CFG_MIN_CORRECTION   = 3'd4;

	// Reset values of the deadband and minimum correction (0.10 in Q1.15).
	localparam logic [14:0] DEADBAND_RST = 15'd3277;
	localparam logic [14:0] MIN_CORR_RST = 15'd3277;

	// Largest drive command magnitude in Q1.15.
	localparam logic signed [16:0] CMD_MAX = 17'sd32767;

	// Mode codes as reported on the result.
	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_HOLD = 2'd1;
	localparam logic [1:0] MODE_SAME = 2'd2;

	typedef enum logic [2:0] {
		ST_OFF  = 3'b001,
		ST_HOLD = 3'b010,
		ST_SAME = 3'b100
	} hold_state_t;

	typedef struct packed {
		logic [15:0] p_gain;
		logic [15:0] d_gain;
		logic [14:0] correction_ratio;
		logic [14:0] deadband;
		logic [14:0] min_correction;
	} cfg_regs_t;

	// One registered control tick.
	typedef struct packed {
		logic signed [15:0] forward_throttle;
		logic signed [15:0] turn_throttle;
		logic               straight_request;
		logic               half_power;
		logic signed [23:0] heading;
		logic signed [15:0] yaw_rate;
		logic               sensor_ready;
	} tick_t;

	// Mode after this tick's update and the heading to hold.
	typedef struct packed {
		logic               hold;
		logic               same;
		logic [1:0]         code;
		logic signed [23:0] target;
	} mode_info_t;

	// Products and control carried from the multiply stage to the mixer.
	typedef struct packed {
		logic signed [15:0] fwd;
		logic signed [15:0] turn;
		logic signed [41:0] p_prod;
		logic signed [32:0] d_prod;
		logic [15:0]        cap;
		logic               hold;
		logic               same;
		logic [1:0]         mode;
		logic               req;
		logic               half;
	} pd_stage_t;

	// A throttle whose magnitude is at or below the deadband becomes zero.
	function automatic logic signed [15:0] dead_zone(input logic signed [15:0] v,
			input logic [14:0] db);
		logic signed [16:0] v_ext;
		logic signed [16:0] lim;
		begin
			v_ext = {v[15], v};
			lim   = $signed({2'b00, db});
			if (v_ext >= -lim && v_ext <= lim) begin
				return '0;
			end
			return v;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/core/hhdm_if.sv]
// Valid/ready channel interfaces of the heading hold drive mixer.
// Depends on nothing; the top level uses them as its ports.
`timescale 1ns / 1ps
`default_nettype none

interface hhdm_tick_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] forward_throttle;
	logic signed [15:0] turn_throttle;
	logic               straight_request;
	logic               half_power;
	logic signed [23:0] heading;
	logic signed [15:0] yaw_rate;
	logic               sensor_ready;

	modport source (output valid, forward_throttle, turn_throttle, straight_request,
		half_power, heading, yaw_rate, sensor_ready, input ready);
	modport sink (input valid, forward_throttle, turn_throttle, straight_request,
		half_power, heading, yaw_rate, sensor_ready, output ready);
endinterface

interface hhdm_drive_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_command;
	logic signed [15:0] right_command;
	logic               drive_active;
	logic [1:0]         mode;

	modport source (output valid, left_command, right_command, drive_active, mode,
		input ready);
	modport sink (input valid, left_command, right_command, drive_active, mode,
		output ready);
endinterface

interface hhdm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/heading_hold_drive_mixer_core.sv]
// Top level of the heading hold drive mixer; instantiates hhdm_mode, hhdm_pd, hhdm_mix.
// Depends on hhdm_pkg, the interfaces in hhdm_if.sv and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

// Differential drive mixer with a PD heading hold. Each request on the tick
// channel carries one control tick and yields exactly one request on the
// drive channel, in order. The block takes one tick per clock cycle while the
// drive channel takes its results; a tick passes through an input register,
// a register behind the three multipliers (error times P, rate times D and
// |forward| times the correction ratio) and the result register. Each stage
// moves on whenever the stage after it is empty or moving, so empty slots
// close up and the tick channel keeps accepting while a result waits to be
// taken. The off / heading hold / same throttle mode and the captured target
// heading are updated as a tick leaves the input register, so consecutive
// ticks see each other's mode exactly as in sequential processing. The
// configuration channel is always ready; a write to an index above four is
// ignored. Registers should be written only while no tick is in flight.
module heading_hold_drive_mixer_core (
	input  wire           clk,
	input  wire           arst_n,
	hhdm_tick_if.sink     tick,
	hhdm_drive_if.source  drive,
	hhdm_cfg_if.sink      cfg
);

	`include "heading_hold_drive_mixer_core_assert.svh"

	hhdm_pkg::cfg_regs_t  cfg_q;
	hhdm_pkg::tick_t      tick_s1;
	hhdm_pkg::mode_info_t mode_info;
	hhdm_pkg::pd_stage_t  pd_s2;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic en1;
	logic en2;
	logic adv3;
	logic step;

	// Configuration registers. Writes are taken at any time.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain           <= '0;
			cfg_q.d_gain           <= '0;
			cfg_q.correction_ratio <= '0;
			cfg_q.deadband         <= hhdm_pkg::DEADBAND_RST;
			cfg_q.min_correction   <= hhdm_pkg::MIN_CORR_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				hhdm_pkg::CFG_P_GAIN:           cfg_q.p_gain           <= cfg.data;
				hhdm_pkg::CFG_D_GAIN:           cfg_q.d_gain           <= cfg.data;
				hhdm_pkg::CFG_CORRECTION_RATIO: cfg_q.correction_ratio <= cfg.data[14:0];
				hhdm_pkg::CFG_DEADBAND:         cfg_q.deadband         <= cfg.data[14:0];
				hhdm_pkg::CFG_MIN_CORRECTION:   cfg_q.min_correction   <= cfg.data[14:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline flow control: a stage loads when it is empty or its content
	// moves on in the same cycle.
	assign adv3       = !v_s3 || drive.ready;
	assign en2        = !v_s2 || adv3;
	assign en1        = !v_s1 || en2;
	assign step       = v_s1 && en2;
	assign tick.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= tick.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Input register; payload needs no reset.
	always_ff @(posedge clk) begin
		if (en1 && tick.valid) begin
			tick_s1.forward_throttle <= tick.forward_throttle;
			tick_s1.turn_throttle    <= tick.turn_throttle;
			tick_s1.straight_request <= tick.straight_request;
			tick_s1.half_power       <= tick.half_power;
			tick_s1.heading          <= tick.heading;
			tick_s1.yaw_rate         <= tick.yaw_rate;
			tick_s1.sensor_ready     <= tick.sensor_ready;
		end
	end

	hhdm_mode u_mode (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.req          (tick_s1.straight_request),
		.sensor_ready (tick_s1.sensor_ready),
		.heading      (tick_s1.heading),
		.info         (mode_info)
	);

	hhdm_pd u_pd (
		.clk   (clk),
		.load  (step),
		.tick  (tick_s1),
		.mi    (mode_info),
		.cfg   (cfg_q),
		.pd_s2 (pd_s2)
	);

	hhdm_mix u_mix (
		.clk            (clk),
		.load           (adv3 && v_s2),
		.pd_s2          (pd_s2),
		.min_correction (cfg_q.min_correction),
		.left_q         (drive.left_command),
		.right_q        (drive.right_command),
		.active_q       (drive.drive_active),
		.mode_q         (drive.mode)
	);

	assign drive.valid = v_s3;

	// A tick leaving the input register always lands in the multiply stage.
	`HHDM_ASSERT_NEXT(a_step_fills_s2, clk, arst_n, step, v_s2,
		"tick left stage one but stage two is empty")
	// Hold and same throttle exist only while go-straight is requested.
	`HHDM_ASSERT_IMP(a_mode_needs_req, clk, arst_n, v_s2 && !pd_s2.req,
		pd_s2.mode == hhdm_pkg::MODE_OFF, "mode is not off without a request")
	// Saturation keeps both commands off the most negative code.
	`HHDM_ASSERT_IMP(a_cmd_range, clk, arst_n, drive.valid,
		drive.left_command != -16'sd32768 && drive.right_command != -16'sd32768,
		"drive command outside the saturation range")
	// The unused mode code never reaches the result.
	`HHDM_ASSERT_IMP(a_mode_code, clk, arst_n, drive.valid,
		drive.mode == hhdm_pkg::MODE_OFF || drive.mode == hhdm_pkg::MODE_HOLD ||
		drive.mode == hhdm_pkg::MODE_SAME, "unused mode code on the result")

endmodule

`default_nettype wire

[rtl/core/hhdm_mode.sv]
// Mode machine of the heading hold drive mixer: off, heading hold, same throttle.
// Depends on hhdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hhdm_mode (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       step,
	input  wire                       req,
	input  wire                       sensor_ready,
	input  wire  signed [23:0]        heading,
	output hhdm_pkg::mode_info_t      info
);

	hhdm_pkg::hold_state_t state_q;
	hhdm_pkg::hold_state_t state_nxt;
	logic signed [23:0]    target_q;
	logic                  capture;

	// The next state is what the tick in stage one sees; it is committed
	// only when that tick moves on.
	always_comb begin
		state_nxt = hhdm_pkg::ST_OFF;
		capture   = 1'b0;
		case (state_q)
			hhdm_pkg::ST_HOLD: begin
				if (!req) begin
					state_nxt = hhdm_pkg::ST_OFF;
				end else if (!sensor_ready) begin
					state_nxt = hhdm_pkg::ST_SAME;
				end else begin
					state_nxt = hhdm_pkg::ST_HOLD;
				end
			end
			hhdm_pkg::ST_SAME: begin
				state_nxt = req ? hhdm_pkg::ST_SAME : hhdm_pkg::ST_OFF;
			end
			default: begin
				if (req && sensor_ready) begin
					state_nxt = hhdm_pkg::ST_HOLD;
					capture   = 1'b1;
				end else if (req) begin
					state_nxt = hhdm_pkg::ST_SAME;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hhdm_pkg::ST_OFF;
			target_q <= '0;
		end else if (step) begin
			state_q <= state_nxt;
			if (capture) begin
				target_q <= heading;
			end
		end
	end

	always_comb begin
		info.hold   = (state_nxt == hhdm_pkg::ST_HOLD);
		info.same   = (state_nxt == hhdm_pkg::ST_SAME);
		info.code   = info.hold ? hhdm_pkg::MODE_HOLD :
			(info.same ? hhdm_pkg::MODE_SAME : hhdm_pkg::MODE_OFF);
		info.target = capture ? heading : target_q;
	end

endmodule

`default_nettype wire

[rtl/core/hhdm_pd.sv]
// Multiply stage: deadband, heading error and the three products, registered.
// Depends on hhdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hhdm_pd (
	input  wire                      clk,
	input  wire                      load,
	input  hhdm_pkg::tick_t          tick,
	input  hhdm_pkg::mode_info_t     mi,
	input  hhdm_pkg::cfg_regs_t      cfg,
	output hhdm_pkg::pd_stage_t      pd_s2
);

	logic signed [15:0] fwd;
	logic signed [15:0] turn;
	logic signed [24:0] err;
	logic signed [16:0] fwd_ext;
	logic signed [16:0] mag_ext;
	logic [15:0]        mag;
	logic signed [41:0] p_mul;
	logic signed [32:0] d_mul;
	logic [30:0]        cap_mul;

	always_comb begin
		fwd     = hhdm_pkg::dead_zone(tick.forward_throttle, cfg.deadband);
		turn    = hhdm_pkg::dead_zone(tick.turn_throttle, cfg.deadband);
		// Full precision error, no wrap at the heading width.
		err     = {mi.target[23], mi.target} - {tick.heading[23], tick.heading};
		fwd_ext = {fwd[15], fwd};
		mag_ext = fwd[15] ? -fwd_ext : fwd_ext;
		mag     = mag_ext[15:0];
		p_mul   = err * $signed({1'b0, cfg.p_gain});
		d_mul   = tick.yaw_rate * $signed({1'b0, cfg.d_gain});
		cap_mul = mag * cfg.correction_ratio;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pd_s2.fwd    <= fwd;
			pd_s2.turn   <= turn;
			pd_s2.p_prod <= p_mul;
			pd_s2.d_prod <= d_mul;
			pd_s2.cap    <= cap_mul[30:15];
			pd_s2.hold   <= mi.hold;
			pd_s2.same   <= mi.same;
			pd_s2.mode   <= mi.code;
			pd_s2.req    <= tick.straight_request;
			pd_s2.half   <= tick.half_power;
		end
	end

endmodule

`default_nettype wire

[rtl/core/hhdm_mix.sv]
// Mixer stage: PD sum, correction cap, left/right mix, saturation and halving.
// Depends on hhdm_pkg; drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module hhdm_mix (
	input  wire                      clk,
	input  wire                      load,
	input  hhdm_pkg::pd_stage_t      pd_s2,
	input  wire  [14:0]              min_correction,
	output logic signed [15:0]       left_q,
	output logic signed [15:0]       right_q,
	output logic                     active_q,
	output logic [1:0]               mode_q
);

	logic signed [42:0] pd_sum;
	logic signed [34:0] pd_div;
	logic [15:0]        cap;
	logic signed [34:0] cap_ext;
	logic signed [15:0] corr;
	logic signed [15:0] turn_sel;
	logic signed [16:0] left_raw;
	logic signed [16:0] right_raw;
	logic signed [15:0] left_sat;
	logic signed [15:0] right_sat;
	logic signed [15:0] left_h;
	logic signed [15:0] right_h;

	always_comb begin
		pd_sum  = {pd_s2.p_prod[41], pd_s2.p_prod}
			- {{10{pd_s2.d_prod[32]}}, pd_s2.d_prod};
		// Arithmetic shift gives the floor of the division by 256.
		pd_div  = pd_sum[42:8];
		cap     = (pd_s2.cap < {1'b0, min_correction}) ? {1'b0, min_correction} : pd_s2.cap;
		cap_ext = $signed({19'b0, cap});
		if (pd_div > cap_ext) begin
			corr = $signed(cap);
		end else if (pd_div < -cap_ext) begin
			corr = -$signed(cap);
		end else begin
			corr = pd_div[15:0];
		end

		if (pd_s2.hold) begin
			turn_sel = corr;
		end else if (pd_s2.same) begin
			turn_sel = '0;
		end else begin
			turn_sel = pd_s2.turn;
		end

		left_raw  = {pd_s2.fwd[15], pd_s2.fwd} - {turn_sel[15], turn_sel};
		right_raw = {pd_s2.fwd[15], pd_s2.fwd} + {turn_sel[15], turn_sel};

		if (left_raw > hhdm_pkg::CMD_MAX) begin
			left_sat = hhdm_pkg::CMD_MAX[15:0];
		end else if (left_raw < -hhdm_pkg::CMD_MAX) begin
			left_sat = -hhdm_pkg::CMD_MAX[15:0];
		end else begin
			left_sat = left_raw[15:0];
		end
		if (right_raw > hhdm_pkg::CMD_MAX) begin
			right_sat = hhdm_pkg::CMD_MAX[15:0];
		end else if (right_raw < -hhdm_pkg::CMD_MAX) begin
			right_sat = -hhdm_pkg::CMD_MAX[15:0];
		end else begin
			right_sat = right_raw[15:0];
		end

		// Halving rounds toward zero: add one to negative values first.
		if (pd_s2.half) begin
			left_h  = (left_sat + $signed({15'b0, left_sat[15]})) >>> 1;
			right_h = (right_sat + $signed({15'b0, right_sat[15]})) >>> 1;
		end else begin
			left_h  = left_sat;
			right_h = right_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q   <= left_h;
			right_q  <= -right_h;
			active_q <= pd_s2.req;
			mode_q   <= pd_s2.mode;
		end
	end

endmodule

`default_nettype wire
